// File: rtl/hitl_pkg.sv
// ----------------------------------------------------------------------------
// hitl_pkg
// Shared types and constants of the hashed intern table: field widths, mix
// constants, result codes and the state encodings of the front and back parts.
// ----------------------------------------------------------------------------
package hitl_pkg;

    // field widths
    localparam int KEY_W    = 16;
    localparam int HANDLE_W = 32;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 2;
    localparam int HASH_W   = 32;

    // stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = 48;
    localparam int OUT_USED_W = STATUS_W + HANDLE_W + SLOT_W;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    // multiply-xorshift mix
    localparam logic [HASH_W-1:0] MIX_MUL   = 32'h045d_9f3b;
    localparam int                MIX_SHIFT = 16;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    // front part: hash and start slot
    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL1,
        F_MUL2,
        F_RED_LO,
        F_RED_HI,
        F_RED_REM,
        F_PUSH
    } front_state_t;

    // back part: clearing pass and probe walk
    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CHECK
    } back_state_t;

endpackage

// File: rtl/hitl_front.sv
// ----------------------------------------------------------------------------
// hitl_front
// Accepts a request, mixes its key with two shared-multiplier rounds and
// reduces the hash to a start slot by reciprocal multiplication (low product,
// high product and quotient, remainder), then queues it.
// ----------------------------------------------------------------------------
module hitl_front #(
    parameter int TABLE_SIZE = 256,
    parameter int IDX_W      = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          enable,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hitl_pkg::KEY_W-1:0]    in_key,
    input  logic [hitl_pkg::HANDLE_W-1:0] in_handle,
    output logic                          push,
    input  logic                          q_full,
    output logic [hitl_pkg::KEY_W-1:0]    out_key,
    output logic [hitl_pkg::HANDLE_W-1:0] out_handle,
    output logic [IDX_W-1:0]              out_start
);
    import hitl_pkg::*;

    // reciprocal of the table size, split into a low and a high part
    localparam int LO_W  = 16;
    localparam int HI_W  = 17;
    localparam int PLO_W = HASH_W + LO_W;
    localparam int PHI_W = HASH_W + HI_W;
    localparam int ACC_W = PHI_W + LO_W;
    localparam int Q_SH  = HASH_W + IDX_W;
    localparam longint unsigned RECIP =
        ((64'd1 << Q_SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
    localparam logic [LO_W-1:0]   RECIP_LO = LO_W'(RECIP);
    localparam logic [HI_W-1:0]   RECIP_HI = HI_W'(RECIP >> LO_W);
    localparam logic [HASH_W-1:0] TS_H     = HASH_W'(TABLE_SIZE);

    front_state_t          state_reg, state_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [HANDLE_W-1:0]   handle_reg, handle_next;
    logic [HASH_W-1:0]     x_reg, x_next;
    logic [IDX_W-1:0]      rem_reg, rem_next;
    logic [PLO_W-1:0]      plo_reg, plo_next;
    logic [HASH_W-1:0]     q_reg, q_next;
    logic [HASH_W-1:0]     mul_a, mul_p;
    logic [PLO_W-1:0]      plo_prod;
    logic [PHI_W-1:0]      phi_prod;
    logic [ACC_W-1:0]      acc;
    logic [HASH_W-1:0]     qd, diff;

    // one shared multiplier for both mix rounds
    assign mul_a = (state_reg == F_MUL1) ? HASH_W'(key_reg)
                                         : ((x_reg >> MIX_SHIFT) ^ x_reg);
    assign mul_p = mul_a * MIX_MUL;

    // quotient by reciprocal, then remainder
    assign plo_prod = {{LO_W{1'b0}}, x_reg} * {{HASH_W{1'b0}}, RECIP_LO};
    assign phi_prod = {{HI_W{1'b0}}, x_reg} * {{HASH_W{1'b0}}, RECIP_HI};
    assign acc      = {phi_prod, {LO_W{1'b0}}} + {{(ACC_W-PLO_W){1'b0}}, plo_reg};
    assign qd       = q_reg * TS_H;
    assign diff     = x_reg - qd;

    assign out_key    = key_reg;
    assign out_handle = handle_reg;
    assign out_start  = rem_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
        x_reg      <= x_next;
        rem_reg    <= rem_next;
        plo_reg    <= plo_next;
        q_reg      <= q_next;
    end

    // next state, hash rounds and reduction to the start slot
    always_comb
    begin
        state_next  = state_reg;
        key_next    = key_reg;
        handle_next = handle_reg;
        x_next      = x_reg;
        rem_next    = rem_reg;
        plo_next    = plo_reg;
        q_next      = q_reg;
        in_ready    = 1'b0;
        push        = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                in_ready = enable;
                if (in_valid && enable)
                begin
                    key_next    = in_key;
                    handle_next = in_handle;
                    state_next  = F_MUL1;
                end
            end
            F_MUL1:
            begin
                x_next     = mul_p;
                state_next = F_MUL2;
            end
            F_MUL2:
            begin
                x_next     = (mul_p >> MIX_SHIFT) ^ mul_p;
                state_next = F_RED_LO;
            end
            F_RED_LO:
            begin
                plo_next   = plo_prod;
                state_next = F_RED_HI;
            end
            F_RED_HI:
            begin
                q_next     = HASH_W'(acc >> Q_SH);
                state_next = F_RED_REM;
            end
            F_RED_REM:
            begin
                rem_next   = diff[IDX_W-1:0];
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                push = !q_full;
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/hitl_queue.sv
// ----------------------------------------------------------------------------
// hitl_queue
// Two-entry request queue between the hashing front and the probing back.
// ----------------------------------------------------------------------------
module hitl_queue #(
    parameter int DATA_W = 56
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output logic [DATA_W-1:0] pop_data
);
    import hitl_pkg::*;

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/hitl_back.sv
// ----------------------------------------------------------------------------
// hitl_back
// Owns the slot memories. Clears the valid store after reset, then walks the
// probe sequence of each queued request and registers one result per request.
// ----------------------------------------------------------------------------
module hitl_back #(
    parameter int TABLE_SIZE = 256,
    parameter int IDX_W      = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          clear_done,
    input  logic                          req_valid,
    output logic                          req_pop,
    input  logic [hitl_pkg::KEY_W-1:0]    req_key,
    input  logic [hitl_pkg::HANDLE_W-1:0] req_handle,
    input  logic [IDX_W-1:0]              req_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hitl_pkg::status_t             out_status,
    output logic [hitl_pkg::HANDLE_W-1:0] out_handle,
    output logic [hitl_pkg::SLOT_W-1:0]   out_slot
);
    import hitl_pkg::*;

    localparam int ENTRY_W = KEY_W + HANDLE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    // slot memories
    logic               valid_mem [TABLE_SIZE];
    logic [ENTRY_W-1:0] entry_mem [TABLE_SIZE];

    back_state_t         state_reg, state_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [HANDLE_W-1:0] out_handle_reg, out_handle_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;

    logic                rd_valid_reg;
    logic [ENTRY_W-1:0]  rd_entry_reg;
    logic [KEY_W-1:0]    rd_key;
    logic [HANDLE_W-1:0] rd_handle;

    logic                valid_we, valid_wdata;
    logic [IDX_W-1:0]    valid_waddr;
    logic                entry_we;
    logic                out_free, slot_empty, slot_hit, probe_last;

    assign rd_key     = rd_entry_reg[KEY_W-1:0];
    assign rd_handle  = rd_entry_reg[ENTRY_W-1:KEY_W];
    assign out_free   = !out_valid_reg || out_ready;
    assign slot_empty = !rd_valid_reg;
    assign slot_hit   = rd_valid_reg && (rd_key == key_reg);
    assign probe_last = (cnt_reg == LAST_IDX);

    assign clear_done = (state_reg != B_CLEAR);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_handle = out_handle_reg;
    assign out_slot   = out_slot_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        cnt_reg        <= cnt_next;
        key_reg        <= key_next;
        handle_reg     <= handle_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
        out_slot_reg   <= out_slot_next;
    end

    // valid store, one read and one write port
    always_ff @(posedge clk)
    begin
        if (valid_we)
        begin
            valid_mem[valid_waddr] <= valid_wdata;
        end
        rd_valid_reg <= valid_mem[addr_reg];
    end

    // key and handle store
    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[addr_reg] <= {handle_reg, key_reg};
        end
        rd_entry_reg <= entry_mem[addr_reg];
    end

    // clearing pass, probe walk and result register
    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        clr_next        = clr_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        out_slot_next   = out_slot_reg;
        valid_we        = 1'b0;
        valid_wdata     = 1'b0;
        valid_waddr     = addr_reg;
        entry_we        = 1'b0;
        req_pop         = 1'b0;
        case (state_reg)
            B_CLEAR:
            begin
                valid_we    = 1'b1;
                valid_waddr = clr_reg;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (req_valid)
                begin
                    req_pop     = 1'b1;
                    key_next    = req_key;
                    handle_next = req_handle;
                    addr_next   = req_start;
                    cnt_next    = '0;
                    state_next  = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                if (slot_empty || slot_hit || probe_last)
                begin
                    // finish once the result register can take it
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = B_IDLE;
                        if (slot_empty)
                        begin
                            valid_we        = 1'b1;
                            valid_wdata     = 1'b1;
                            entry_we        = 1'b1;
                            out_status_next = ST_INSERTED;
                            out_handle_next = handle_reg;
                            out_slot_next   = SLOT_W'(addr_reg);
                        end
                        else if (slot_hit)
                        begin
                            out_status_next = ST_HIT;
                            out_handle_next = rd_handle;
                            out_slot_next   = SLOT_W'(addr_reg);
                        end
                        else
                        begin
                            out_status_next = ST_FULL;
                            out_handle_next = '0;
                            out_slot_next   = '0;
                        end
                    end
                end
                else
                begin
                    // next slot with wraparound
                    cnt_next   = cnt_reg + 1'b1;
                    addr_next  = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
                    state_next = B_READ;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/hashed_intern_table_lookup_insert_unit.sv
// ----------------------------------------------------------------------------
// hashed_intern_table_lookup_insert_unit
// Get-or-insert intern table with open addressing and linear probing.
// ----------------------------------------------------------------------------
// Each request carries a 16-bit key and a handle; the result says whether the
// key was found (stored handle returned), inserted (new handle returned) or
// the table is full. After reset the block runs a clearing pass over every
// slot of the valid store and accepts no request until it is over.
// A request passes through the hashing front in order: accept, two rounds on
// the shared 32x32 multiplier, reciprocal reduction to the start slot (low
// product, high product and quotient, remainder) and queue push. The probing
// back pops it and reads and checks the slots it visits in turn through the
// single registered read port of the slot memories; on a full table it visits
// every slot. Front and back overlap through a two-entry queue, so the front
// can take new requests while the back probes, until the queue is full.
// ----------------------------------------------------------------------------
module hashed_intern_table_lookup_insert_unit #(
    parameter int TABLE_SIZE = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // key [15:0], new_handle [47:16]
    input  logic [hitl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status [1:0], handle [33:2], slot [41:34], zero [47:42]
    output logic [hitl_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import hitl_pkg::*;

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int Q_W   = IDX_W + HANDLE_W + KEY_W;

    logic                clear_done;
    logic                push, q_full, q_empty, q_pop;
    logic [KEY_W-1:0]    f_key, b_key;
    logic [HANDLE_W-1:0] f_handle, b_handle;
    logic [IDX_W-1:0]    f_start, b_start;
    logic [Q_W-1:0]      q_in, q_out;
    status_t             res_status;
    logic [HANDLE_W-1:0] res_handle;
    logic [SLOT_W-1:0]   res_slot;

    // hashing front
    hitl_front #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (clear_done),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_key     (s_axis_tdata[KEY_W-1:0]),
        .in_handle  (s_axis_tdata[KEY_W+HANDLE_W-1:KEY_W]),
        .push       (push),
        .q_full     (q_full),
        .out_key    (f_key),
        .out_handle (f_handle),
        .out_start  (f_start)
    );

    // request queue
    assign q_in = {f_start, f_handle, f_key};

    hitl_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    assign b_key    = q_out[KEY_W-1:0];
    assign b_handle = q_out[KEY_W+HANDLE_W-1:KEY_W];
    assign b_start  = q_out[Q_W-1:KEY_W+HANDLE_W];

    // probing back
    hitl_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_done (clear_done),
        .req_valid  (!q_empty),
        .req_pop    (q_pop),
        .req_key    (b_key),
        .req_handle (b_handle),
        .req_start  (b_start),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (res_status),
        .out_handle (res_handle),
        .out_slot   (res_slot)
    );

    // result packing
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_slot, res_handle, res_status};

endmodule
